@@ src/first_fit_aligned_allocator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFAA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffaa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffaa assertion failed");

`endif

@@ src/ffaa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared types and constants of the first-fit aligned allocator.
// ----------------------------------------------------------------------------
package ffaa_pkg;

  localparam int MaxBlocks = 64;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int AddrW     = 32;
  localparam int AlogW     = 5;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_ZERO    = 3'd5
  } status_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
    logic             busy;
  } ent_t;

  localparam int EntW = 2 * AddrW + 1;

  typedef struct packed {
    cmd_t             cmd;
    logic             zero;
    logic [AddrW-1:0] size;
    logic [AlogW-1:0] alog;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] len;
  } job_t;

endpackage

@@ src/first_fit_aligned_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_aligned_allocator
// First-fit aligned allocator over an address-sorted block table.
//
//   Channel  Handshake                        Payload
//   in       push / full                      command, request_size, align_log2,
//                                             free_address
//   out      empty / pop                      status, grant_addr
//   cfg      psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// Init and requests refused up front are answered from idle. An allocate
// scans one entry per cycle to the first fit, then shifts each entry above the
// split up (a read and a write state) and writes up to two new entries. A free
// scans one entry per cycle, merges, and shifts each entry above the merge down.
// An unread result beat stalls the engine, and full rises when two requests
// wait. Reset is synchronous and leaves the table memory uncleared.
// ----------------------------------------------------------------------------
module first_fit_aligned_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_command,
  input  logic [ffaa_pkg::AddrW-1:0] in_request_size,
  input  logic [ffaa_pkg::AlogW-1:0] in_align_log2,
  input  logic [ffaa_pkg::AddrW-1:0] in_free_address,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [2:0]                 out_status,
  output logic [ffaa_pkg::AddrW-1:0] out_grant_addr,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [31:0]    pool_base_r, pool_length_r;
  logic           job_valid, job_ready;
  ffaa_pkg::job_t job;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? pool_length_r : pool_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      pool_length_r <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2]) begin
        pool_length_r <= cfg_pwdata;
      end else begin
        pool_base_r <= cfg_pwdata;
      end
    end
  end

  ffaa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_request_size(in_request_size),
    .in_align_log2  (in_align_log2),
    .in_free_address(in_free_address),
    .pool_base      (pool_base_r),
    .pool_length    (pool_length_r),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job)
  );

  ffaa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_status    (out_status),
    .out_grant_addr(out_grant_addr)
  );

endmodule

@@ src/ffaa_ram.sv @@
// ----------------------------------------------------------------------------
// ffaa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffaa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ffaa_front.sv @@
// ----------------------------------------------------------------------------
// ffaa_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ffaa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_command,
  input  logic [ffaa_pkg::AddrW-1:0]     in_request_size,
  input  logic [ffaa_pkg::AlogW-1:0]     in_align_log2,
  input  logic [ffaa_pkg::AddrW-1:0]     in_free_address,
  input  logic [ffaa_pkg::AddrW-1:0]     pool_base,
  input  logic [ffaa_pkg::AddrW-1:0]     pool_length,
  output logic                           job_valid,
  input  logic                           job_ready,
  output ffaa_pkg::job_t                 job
);

  ffaa_pkg::job_t             q_r [2];
  logic                       wp_r, rp_r;
  logic [1:0]                 cnt_r;
  ffaa_pkg::job_t             cls;
  logic [ffaa_pkg::AddrW-1:0] room;
  logic                       push_ok, pop_ok;

  always_comb begin
    room       = ~pool_base;
    cls.cmd    = ffaa_pkg::cmd_t'(in_command);
    cls.size   = in_request_size;
    cls.alog   = in_align_log2;
    cls.addr   = in_free_address;
    cls.len    = pool_length;
    cls.zero   = 1'b0;
    case (cls.cmd)
      ffaa_pkg::CMD_INIT: begin
        cls.addr = pool_base;
        cls.zero = (pool_length == '0);
        if ((pool_length - 1'b1) > room) begin
          cls.len = room + 1'b1;
        end
      end
      ffaa_pkg::CMD_ALLOC: cls.zero = (in_request_size == '0);
      default: cls.zero = 1'b0;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        q_r[wp_r] <= cls;
        wp_r      <= !wp_r;
      end
      if (pop_ok) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

@@ src/ffaa_back.sv @@
// ----------------------------------------------------------------------------
// ffaa_back
// Executes requests on the block table and holds the result beat.
// ----------------------------------------------------------------------------
module ffaa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  ffaa_pkg::job_t             job,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [2:0]                 out_status,
  output logic [ffaa_pkg::AddrW-1:0] out_grant_addr
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FSCAN, S_NEXT, S_MERGE,
    S_SHD, S_SHD_WR, S_SHU, S_SHU_WR, S_INS1, S_INS2
  } state_t;

  localparam int AW = ffaa_pkg::AddrW;
  localparam int CW = ffaa_pkg::CntW;
  localparam int IW = ffaa_pkg::IdxW;

  state_t            state_r;
  ffaa_pkg::job_t    job_r;
  logic [CW-1:0]     cnt_r, idx_r, k_r;
  logic [1:0]        n_r, d_r;
  ffaa_pkg::ent_t    prev_r, cur_r, next_r, ins0_r, ins1_r;
  logic              has_next_r;
  logic              res_valid_r;
  ffaa_pkg::status_t res_status_r;
  logic [AW-1:0]     res_addr_r;

  logic                       we;
  logic [IW-1:0]              waddr, raddr;
  ffaa_pkg::ent_t             wdata, e;
  logic [ffaa_pkg::EntW-1:0]  rdata;

  logic [AW-1:0] amask, off, tail, aaddr, tstart, wlen;
  logic [AW:0]   avail;
  logic [1:0]    need, d_m;
  logic          fits, over, more, pf, nf;
  logic [CW:0]   need_sum;

  ffaa_ram #(.Width(ffaa_pkg::EntW), .Depth(ffaa_pkg::MaxBlocks)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    e        = ffaa_pkg::ent_t'(rdata);
    amask    = ~({AW{1'b1}} << job_r.alog);
    off      = (~e.start + 1'b1) & amask;
    avail    = {1'b0, e.len} - {1'b0, off};
    fits     = !e.busy && !avail[AW] && (job_r.size <= avail[AW-1:0]);
    tail     = avail[AW-1:0] - job_r.size;
    need     = {1'b0, off != '0} + {1'b0, tail != '0};
    need_sum = {1'b0, cnt_r} + {{(CW-1){1'b0}}, need};
    over     = need_sum > (CW+1)'(ffaa_pkg::MaxBlocks);
    aaddr    = e.start + off;
    tstart   = aaddr + job_r.size;
    more     = (idx_r + 1'b1) < cnt_r;
    pf       = (idx_r != '0) && !prev_r.busy;
    nf       = has_next_r && !next_r.busy;
    d_m      = {1'b0, pf} + {1'b0, nf};
    wlen     = (pf ? prev_r.len : '0) + cur_r.len + (nf ? next_r.len : '0);
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = e;
    raddr = '0;
    case (state_r)
      S_IDLE: begin
        we    = job_valid && !res_valid_r && (job.cmd == ffaa_pkg::CMD_INIT) && !job.zero;
        wdata = '{start: job.addr, len: job.len, busy: 1'b0};
      end
      S_SCAN: begin
        raddr = IW'(idx_r + 1'b1);
        we    = fits && !over;
        waddr = idx_r[IW-1:0];
        if (off == '0) begin
          wdata = '{start: e.start, len: job_r.size, busy: 1'b1};
        end else begin
          wdata = '{start: e.start, len: off, busy: 1'b0};
        end
      end
      S_FSCAN: raddr = IW'(idx_r + 1'b1);
      S_MERGE: begin
        we    = 1'b1;
        waddr = pf ? IW'(idx_r - 1'b1) : idx_r[IW-1:0];
        wdata = '{start: (pf ? prev_r.start : cur_r.start), len: wlen, busy: 1'b0};
      end
      S_SHD, S_SHU: raddr = k_r[IW-1:0];
      S_SHD_WR: begin
        we    = 1'b1;
        waddr = IW'(k_r - {{(CW-2){1'b0}}, d_r});
      end
      S_SHU_WR: begin
        we    = 1'b1;
        waddr = IW'(k_r + {{(CW-2){1'b0}}, n_r});
      end
      S_INS1: begin
        we    = 1'b1;
        waddr = IW'(idx_r + 1'b1);
        wdata = ins0_r;
      end
      S_INS2: begin
        we    = 1'b1;
        waddr = IW'(idx_r + 2'd2);
        wdata = ins1_r;
      end
      default: we = 1'b0;
    endcase
  end

  assign job_ready      = (state_r == S_IDLE) && !res_valid_r;
  assign out_empty      = !res_valid_r;
  assign out_status     = res_status_r;
  assign out_grant_addr = res_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid && !res_valid_r) begin
            job_r      <= job;
            idx_r      <= '0;
            res_addr_r <= '0;
            case (job.cmd)
              ffaa_pkg::CMD_INIT: begin
                res_valid_r  <= 1'b1;
                res_status_r <= job.zero ? ffaa_pkg::ST_ZERO : ffaa_pkg::ST_OK;
                if (!job.zero) begin
                  cnt_r <= CW'(1);
                end
              end
              ffaa_pkg::CMD_ALLOC: begin
                if (job.zero || cnt_r == '0) begin
                  res_valid_r  <= 1'b1;
                  res_status_r <= job.zero ? ffaa_pkg::ST_ZERO : ffaa_pkg::ST_NOFIT;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              ffaa_pkg::CMD_FREE: begin
                if (cnt_r == '0) begin
                  res_valid_r  <= 1'b1;
                  res_status_r <= ffaa_pkg::ST_UNKNOWN;
                end else begin
                  state_r <= S_FSCAN;
                end
              end
              default: begin
                res_valid_r  <= 1'b1;
                res_status_r <= ffaa_pkg::ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (fits) begin
            if (over) begin
              res_valid_r  <= 1'b1;
              res_status_r <= ffaa_pkg::ST_FULL;
              state_r      <= S_IDLE;
            end else begin
              k_r <= cnt_r - 1'b1;
              if (off == '0) begin
                n_r    <= {1'b0, tail != '0};
                ins0_r <= '{start: tstart, len: tail, busy: 1'b0};
              end else begin
                n_r    <= need;
                ins0_r <= '{start: aaddr, len: job_r.size, busy: 1'b1};
                ins1_r <= '{start: tstart, len: tail, busy: 1'b0};
              end
              if (need == 2'd0) begin
                res_valid_r  <= 1'b1;
                res_status_r <= ffaa_pkg::ST_OK;
                res_addr_r   <= aaddr;
                state_r      <= S_IDLE;
              end else begin
                res_addr_r <= aaddr;
                state_r    <= S_SHU;
              end
            end
          end else if (more) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            res_valid_r  <= 1'b1;
            res_status_r <= ffaa_pkg::ST_NOFIT;
            state_r      <= S_IDLE;
          end
        end
        S_FSCAN: begin
          if (e.start == job_r.addr) begin
            cur_r      <= e;
            has_next_r <= 1'b0;
            if (!e.busy) begin
              res_valid_r  <= 1'b1;
              res_status_r <= ffaa_pkg::ST_DOUBLE;
              state_r      <= S_IDLE;
            end else begin
              state_r <= more ? S_NEXT : S_MERGE;
            end
          end else if (e.start > job_r.addr || !more) begin
            res_valid_r  <= 1'b1;
            res_status_r <= ffaa_pkg::ST_UNKNOWN;
            state_r      <= S_IDLE;
          end else begin
            prev_r <= e;
            idx_r  <= idx_r + 1'b1;
          end
        end
        S_NEXT: begin
          next_r     <= e;
          has_next_r <= 1'b1;
          state_r    <= S_MERGE;
        end
        S_MERGE: begin
          d_r <= d_m;
          k_r <= idx_r + 1'b1 + {{(CW-1){1'b0}}, nf};
          if (d_m == 2'd0) begin
            res_valid_r  <= 1'b1;
            res_status_r <= ffaa_pkg::ST_OK;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_SHD;
          end
        end
        S_SHD: begin
          if (k_r < cnt_r) begin
            state_r <= S_SHD_WR;
          end else begin
            cnt_r        <= cnt_r - {{(CW-2){1'b0}}, d_r};
            res_valid_r  <= 1'b1;
            res_status_r <= ffaa_pkg::ST_OK;
            state_r      <= S_IDLE;
          end
        end
        S_SHD_WR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_SHD;
        end
        S_SHU: begin
          state_r <= (k_r > idx_r) ? S_SHU_WR : S_INS1;
        end
        S_SHU_WR: begin
          k_r     <= k_r - 1'b1;
          state_r <= S_SHU;
        end
        S_INS1: begin
          if (n_r == 2'd2) begin
            state_r <= S_INS2;
          end else begin
            cnt_r        <= cnt_r + {{(CW-2){1'b0}}, n_r};
            res_valid_r  <= 1'b1;
            res_status_r <= ffaa_pkg::ST_OK;
            state_r      <= S_IDLE;
          end
        end
        S_INS2: begin
          cnt_r        <= cnt_r + {{(CW-2){1'b0}}, n_r};
          res_valid_r  <= 1'b1;
          res_status_r <= ffaa_pkg::ST_OK;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/ffaa_checker.sv @@
// ----------------------------------------------------------------------------
// ffaa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_aligned_allocator_assert.svh"

module ffaa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [2:0]                 out_status,
  input logic [ffaa_pkg::AddrW-1:0] out_grant_addr,
  input logic                       cfg_pready
);

  logic vld, err_vld, held;

  assign vld     = !out_empty;
  assign err_vld = vld && (out_status != ffaa_pkg::ST_OK);
  assign held    = vld && !out_pop;

  `FFAA_ASSERT_NOW(a_addr_zero_on_error, clk, rst_n, err_vld, out_grant_addr == '0)
  `FFAA_ASSERT_NOW(a_status_legal, clk, rst_n, vld, out_status <= ffaa_pkg::ST_ZERO)
  `FFAA_ASSERT_NEXT(a_result_held, clk, rst_n, held, vld && $stable({out_status, out_grant_addr}))
  `FFAA_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind first_fit_aligned_allocator ffaa_checker u_ffaa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_status    (out_status),
  .out_grant_addr(out_grant_addr),
  .cfg_pready    (cfg_pready)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// First-fit aligned allocator testbench
// Drives init, allocate, free and no-op requests via the queue-style input,
// predicts every status and grant address with a table model of its own, and
// compares each result beat in order. Pool settings are changed between
// phases over the register port, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegPoolBase   = 3'd0;
  localparam logic [2:0] RegPoolLength = 3'd4;
  localparam int         EngineDrain   = 250;

  typedef struct {
    ffaa_pkg::cmd_t    cmd;
    logic [31:0]       size;
    logic [4:0]        alog;
    logic [31:0]       addr;
    bit                typed;
    ffaa_pkg::status_t exp_st;
    logic [31:0]       exp_addr;
  } req_t;

  typedef struct {
    ffaa_pkg::status_t st;
    logic [31:0]       addr;
  } answer_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [1:0]  in_command = '0;
  logic [31:0] in_request_size = '0;
  logic [4:0]  in_align_log2 = '0;
  logic [31:0] in_free_address = '0;
  logic        out_empty;
  logic        out_pop = 0;
  logic [2:0]  out_status;
  logic [31:0] out_grant_addr;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  first_fit_aligned_allocator dut (.*);

  initial forever #5 clk = ~clk;

  // Own copy of the block table and the pool settings.
  logic [31:0] tbl_start [ffaa_pkg::MaxBlocks];
  logic [31:0] tbl_len   [ffaa_pkg::MaxBlocks];
  bit          tbl_busy  [ffaa_pkg::MaxBlocks];
  int          tbl_count;
  logic [31:0] pool_base_q;
  logic [31:0] pool_len_q;

  answer_t     pending_answers[$];
  logic [31:0] live_blocks[$];
  int          failures = 0;
  bit          stall_rx = 1;
  bit          stall_tx = 1;
  int          hold_request = 0;

  function automatic void tbl_insert(int pos, logic [31:0] s, logic [31:0] l, bit b);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k]   = tbl_len[k-1];
      tbl_busy[k]  = tbl_busy[k-1];
    end
    tbl_start[pos] = s;
    tbl_len[pos]   = l;
    tbl_busy[pos]  = b;
    tbl_count++;
  endfunction

  function automatic void tbl_erase(int pos);
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k]   = tbl_len[k+1];
      tbl_busy[k]  = tbl_busy[k+1];
    end
    tbl_count--;
  endfunction

  function automatic answer_t allocate_predict(logic [31:0] size, logic [4:0] alog);
    answer_t     a;
    logic [31:0] amask, s, l, off, tail, at;
    int          need;
    a.st = ffaa_pkg::ST_NOFIT;
    a.addr = '0;
    amask = (32'd1 << alog) - 32'd1;
    if (size == 0) begin
      a.st = ffaa_pkg::ST_ZERO;
      return a;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i]) continue;
      s = tbl_start[i];
      l = tbl_len[i];
      off = (~s + 32'd1) & amask;
      if (off > l || size > l - off) continue;
      tail = l - off - size;
      need = (off != 0) + (tail != 0);
      if (tbl_count + need > ffaa_pkg::MaxBlocks) begin
        a.st = ffaa_pkg::ST_FULL;
        return a;
      end
      at = s + off;
      if (off == 0) begin
        tbl_len[i] = size;
        tbl_busy[i] = 1;
        if (tail != 0) tbl_insert(i + 1, at + size, tail, 0);
      end else begin
        tbl_len[i] = off;
        tbl_insert(i + 1, at, size, 1);
        if (tail != 0) tbl_insert(i + 2, at + size, tail, 0);
      end
      a.st = ffaa_pkg::ST_OK;
      a.addr = at;
      return a;
    end
    return a;
  endfunction

  function automatic ffaa_pkg::status_t release_predict(logic [31:0] at);
    int idx = 0;
    while (idx < tbl_count && tbl_start[idx] < at) idx++;
    if (idx >= tbl_count || tbl_start[idx] != at) return ffaa_pkg::ST_UNKNOWN;
    if (!tbl_busy[idx]) return ffaa_pkg::ST_DOUBLE;
    tbl_busy[idx] = 0;
    if (idx > 0 && !tbl_busy[idx-1]) begin
      tbl_len[idx-1] += tbl_len[idx];
      tbl_erase(idx);
      idx--;
    end
    if (idx + 1 < tbl_count && !tbl_busy[idx+1]) begin
      tbl_len[idx] += tbl_len[idx+1];
      tbl_erase(idx + 1);
    end
    return ffaa_pkg::ST_OK;
  endfunction

  function automatic answer_t allocator_predict(req_t r);
    answer_t     a;
    logic [31:0] room, l;
    a.st = ffaa_pkg::ST_OK;
    a.addr = '0;
    case (r.cmd)
      ffaa_pkg::CMD_INIT: begin
        room = 32'hFFFF_FFFF - pool_base_q;
        l = pool_len_q;
        if (l == 0) begin
          a.st = ffaa_pkg::ST_ZERO;
        end else begin
          if (l - 32'd1 > room) l = room + 32'd1;
          tbl_count = 1;
          tbl_start[0] = pool_base_q;
          tbl_len[0] = l;
          tbl_busy[0] = 0;
          live_blocks.delete();
        end
      end
      ffaa_pkg::CMD_ALLOC: begin
        a = allocate_predict(r.size, r.alog);
        if (a.st == ffaa_pkg::ST_OK) live_blocks.push_back(a.addr);
      end
      ffaa_pkg::CMD_FREE: a.st = release_predict(r.addr);
      default: ;
    endcase
    return a;
  endfunction

  task automatic reg_write(logic [2:0] where, logic [31:0] value);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= where;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    if (where == RegPoolBase) pool_base_q = value;
    else pool_len_q = value;
  endtask

  task automatic wait_drained();
    in_push <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (EngineDrain) @(posedge clk);
  endtask

  task automatic set_pool(logic [31:0] base, logic [31:0] len);
    wait_drained();
    reg_write(RegPoolBase, base);
    reg_write(RegPoolLength, len);
  endtask

  task automatic send(req_t r);
    int      gap;
    answer_t a;
    gap = stall_tx ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1;
    in_command      <= r.cmd;
    in_request_size <= r.size;
    in_align_log2   <= r.alog;
    in_free_address <= r.addr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    a = allocator_predict(r);
    if (r.typed) begin
      a.st = r.exp_st;
      a.addr = r.exp_addr;
    end
    pending_answers.push_back(a);
  endtask

  function automatic req_t random_request(int size_max, int alog_max);
    req_t r;
    int   pick = $urandom_range(0, 99);
    r.typed = 0;
    r.size = $urandom_range(1, size_max);
    r.alog = 5'($urandom_range(0, alog_max));
    r.addr = $urandom;
    r.cmd = ffaa_pkg::CMD_ALLOC;
    if (pick < 3) begin
      r.cmd = ffaa_pkg::CMD_INIT;
    end else if (pick < 6) begin
      r.cmd = ffaa_pkg::CMD_NOP;
    end else if (pick < 10) begin
      r.size = $urandom;
      r.alog = 5'($urandom);
    end else if (pick < 12) begin
      r.size = 0;
    end else if (pick < 50) begin
      r.cmd = ffaa_pkg::CMD_FREE;
      if (live_blocks.size() != 0 && pick < 44) begin
        int k = $urandom_range(0, live_blocks.size() - 1);
        r.addr = live_blocks[k];
        if (pick < 40) live_blocks.delete(k);
      end else if (pick < 47) begin
        r.addr = pool_base_q + $urandom_range(0, 64);
      end
    end
    return r;
  endfunction

  req_t directed[] = '{
    '{ffaa_pkg::CMD_ALLOC, 32'd16, 5'd0, 32'd0, 1, ffaa_pkg::ST_NOFIT, 32'd0},
    '{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'd0, 1, ffaa_pkg::ST_UNKNOWN, 32'd0},
    '{ffaa_pkg::CMD_NOP, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_INIT, 32'd0, 5'd0, 32'd0, 1, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'd0, 5'd3, 32'd0, 1, ffaa_pkg::ST_ZERO, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h100, 5'd0, 32'd0, 1, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h10, 5'd12, 32'd0, 1, ffaa_pkg::ST_OK, 32'h1000},
    '{ffaa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 5'd0, 32'd0, 1, ffaa_pkg::ST_NOFIT, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h1, 5'd31, 32'd0, 1, ffaa_pkg::ST_NOFIT, 32'd0},
    '{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'd0, 1, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'd0, 1, ffaa_pkg::ST_DOUBLE, 32'd0},
    '{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'h1234, 1, ffaa_pkg::ST_UNKNOWN, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h20, 5'd4, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'h1000, 0, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h8000, 5'd15, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_ALLOC, 32'h1, 5'd1, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0},
    '{ffaa_pkg::CMD_INIT, 32'd0, 5'd0, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0}
  };

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    pool_base_q = 32'd0;
    pool_len_q = 32'd65536;
    tbl_count = 0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);

    set_pool(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send('{ffaa_pkg::CMD_INIT, 32'd0, 5'd0, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0});
    send('{ffaa_pkg::CMD_ALLOC, 32'd16, 5'd0, 32'd0, 1, ffaa_pkg::ST_OK, 32'hFFFF_FFF0});
    send('{ffaa_pkg::CMD_ALLOC, 32'd1, 5'd31, 32'd0, 1, ffaa_pkg::ST_NOFIT, 32'd0});
    set_pool(32'h0, 32'h0);
    send('{ffaa_pkg::CMD_INIT, 32'd0, 5'd0, 32'd0, 1, ffaa_pkg::ST_ZERO, 32'd0});
    send('{ffaa_pkg::CMD_FREE, 32'd0, 5'd0, 32'hFFFF_FFF0, 1, ffaa_pkg::ST_OK, 32'd0});

    for (int ph = 0; ph < 6; ph++) begin
      int size_max, alog_max;
      case (ph)
        0: begin set_pool(32'h0, 32'd256);             size_max = 3;  alog_max = 2;  end
        1: begin set_pool(32'h1000, 32'd65536);        size_max = 4096; alog_max = 8; end
        2: begin set_pool(32'h8000_0000, 32'hFFFF_FFFF); size_max = 1 << 20; alog_max = 31; end
        3: begin set_pool(32'hFFFF_FFFF, 32'd1);       size_max = 2;  alog_max = 1;  end
        4: begin set_pool($urandom, $urandom_range(1, 1024)); size_max = 64; alog_max = 5; end
        default: begin set_pool(32'h0, 32'd128);       size_max = 2;  alog_max = 1;  end
      endcase
      stall_tx = (ph != 1);
      stall_rx = (ph != 1);
      send('{ffaa_pkg::CMD_INIT, 32'd0, 5'd0, 32'd0, 0, ffaa_pkg::ST_OK, 32'd0});
      for (int n = 0; n < 105; n++) begin
        if (ph == 4 && n == 30) hold_request = 400;
        if (n == 60) begin
          in_push <= 0;
          while (pending_answers.size() != 0) @(posedge clk);
        end
        send(random_request(size_max, alog_max));
      end
    end
    in_push <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (EngineDrain) @(posedge clk);
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    int      n;
    answer_t e;
    forever begin
      n = stall_rx ? $urandom_range(0, 4) : 0;
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end
      if (n > 0) begin
        out_pop <= 0;
        repeat (n) @(posedge clk);
      end
      out_pop <= 1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (pending_answers.size() == 0) begin
        $display("%0t: beat with nothing expected: status %0d address %h",
                 $time, out_status, out_grant_addr);
        failures++;
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
          failures++;
        end
        if (out_grant_addr !== e.addr) begin
          $display("%0t: grant address expected %h actual %h",
                   $time, e.addr, out_grant_addr);
          failures++;
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/ffaa_pkg.sv
src/ffaa_ram.sv
src/ffaa_front.sv
src/ffaa_back.sv
src/first_fit_aligned_allocator.sv
src/ffaa_checker.sv
tb/sv/testbench.sv
